// File: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the LRU page replacement block: controller
// states, controller-to-datapath commands and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  // fixed field widths of the transaction ports
  localparam int unsigned PAGE_PORT_W = 16;
  localparam int unsigned FRAME_IDX_W = 2;
  localparam int unsigned FAULT_W     = 32;
  localparam int unsigned CFG_W       = 3;

  // frames_in_use after reset
  localparam logic [CFG_W-1:0]   CFG_RESET = 3'd3;
  // saturation value of the fault counter
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;    // register the incoming reference
    logic execute;    // lookup, replace and form the result
    logic cfg_write;  // load frames_in_use
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Controller: takes a reference when idle, runs one execute cycle for it and
// gates configuration writes to idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            cfg_valid,
  output logic                 busy,
  output lpr_pkg::dp_cmd_t     cmd
);

  lpr_pkg::ctl_state_t state_r;
  lpr_pkg::ctl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    busy          = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    cmd.cfg_write = 1'b0;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = lpr_pkg::ST_EXEC;
        end
      end
      lpr_pkg::ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        state_nxt   = lpr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  // a captured reference is executed in the very next cycle
  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute)
    else $error("captured reference not executed");

  // execute lasts a single cycle
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> !cmd.execute)
    else $error("execute held for more than one cycle");

endmodule

`default_nettype wire

// File: rtl/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// Frame table, recency ranks, fault counter and result registers. In the
// execute cycle all active frames are compared in parallel, the slot is
// picked (hit, first empty, or oldest rank) and the table is updated.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_datapath #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lpr_pkg::dp_cmd_t                    cmd,
  input  wire logic [lpr_pkg::PAGE_PORT_W-1:0]     in_page,
  input  wire logic                                in_end_of_run,
  input  wire logic [lpr_pkg::CFG_W-1:0]           cfg_frames_in_use,
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic [lpr_pkg::FRAME_IDX_W-1:0]          out_frame_used,
  output logic                                     out_evicted_valid,
  output logic [lpr_pkg::PAGE_PORT_W-1:0]          out_evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]              out_fault_total,
  output logic                                     out_run_done
);

  localparam int unsigned SW = $clog2(FRAMES);
  localparam int unsigned RW = $clog2(FRAMES);
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

  // configuration and captured reference
  logic [lpr_pkg::CFG_W-1:0] frames_r;
  logic [PAGE_BITS-1:0]      page_r;
  logic                      eor_r;

  // frame table
  logic [PAGE_BITS-1:0]      frame_page_r  [FRAMES];
  logic [PAGE_BITS-1:0]      frame_page_nxt[FRAMES];
  logic [FRAMES-1:0]         frame_valid_r;
  logic [FRAMES-1:0]         frame_valid_nxt;
  logic [RW-1:0]             rank_r  [FRAMES];
  logic [RW-1:0]             rank_nxt[FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_cnt_r;
  logic [lpr_pkg::FAULT_W-1:0] fault_cnt_nxt;

  // result registers
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [lpr_pkg::FRAME_IDX_W-1:0]   out_frame_r;
  logic                              out_ev_valid_r;
  logic [lpr_pkg::PAGE_PORT_W-1:0]   out_ev_page_r;
  logic [lpr_pkg::FAULT_W-1:0]       out_fault_r;
  logic                              out_done_r;

  // lookup signals
  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] empty;
  logic              found;
  logic              has_empty;
  logic [SW-1:0]     hit_slot;
  logic [SW-1:0]     empty_slot;
  logic [SW-1:0]     victim;
  logic [SW-1:0]     slot;
  logic [RW-1:0]     hit_rank;
  logic              ev_valid;
  logic [lpr_pkg::PAGE_PORT_W-1:0] ev_page;

  // compare, pick the slot
  always_comb begin
    found      = 1'b0;
    has_empty  = 1'b0;
    hit_slot   = '0;
    empty_slot = '0;
    victim     = '0;
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (32'(i) < 32'(frames_r));
      match[i]  = active[i] && frame_valid_r[i] && (frame_page_r[i] == page_r);
      empty[i]  = active[i] && !frame_valid_r[i];
    end
    // lowest index wins: scan from the top down
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found    = 1'b1;
        hit_slot = SW'(i);
      end
      if (empty[i]) begin
        has_empty  = 1'b1;
        empty_slot = SW'(i);
      end
    end
    // oldest active rank, lowest index on a tie
    for (int i = 1; i < FRAMES; i++) begin
      if (active[i] && (rank_r[i] > rank_r[victim])) begin
        victim = SW'(i);
      end
    end
    if (found) begin
      slot = hit_slot;
    end else if (has_empty) begin
      slot = empty_slot;
    end else begin
      slot = victim;
    end
    hit_rank = rank_r[slot];
    ev_valid = !found && !has_empty;
    ev_page  = ev_valid ? lpr_pkg::PAGE_PORT_W'(frame_page_r[slot]) : '0;
  end

  // table and counter update
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      frame_page_nxt[i]  = frame_page_r[i];
      frame_valid_nxt[i] = frame_valid_r[i];
      rank_nxt[i]        = rank_r[i];
      if (SW'(i) == slot) begin
        rank_nxt[i] = '0;
        if (!found) begin
          frame_page_nxt[i]  = page_r;
          frame_valid_nxt[i] = 1'b1;
        end
      end else if (active[i] && frame_valid_r[i] && (!found || (rank_r[i] < hit_rank))
                   && (rank_r[i] < RANK_MAX)) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
    end
    if (found || (fault_cnt_r == lpr_pkg::FAULT_MAX)) begin
      fault_cnt_nxt = fault_cnt_r;
    end else begin
      fault_cnt_nxt = fault_cnt_r + 1'b1;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lpr_pkg::CFG_RESET;
    end else if (cmd.cfg_write) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  // captured reference
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= PAGE_BITS'(in_page);
      eor_r  <= in_end_of_run;
    end
  end

  // frame pages hold no reset, only valid frames are ever read
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page_r[i] <= frame_page_nxt[i];
      end
    end
  end

  // valid bits, ranks and fault counter; end of run clears them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_cnt_r   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      if (eor_r) begin
        frame_valid_r <= '0;
        fault_cnt_r   <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= '0;
        end
      end else begin
        frame_valid_r <= frame_valid_nxt;
        fault_cnt_r   <= fault_cnt_nxt;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.execute;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_hit_r      <= found;
      out_frame_r    <= lpr_pkg::FRAME_IDX_W'(slot);
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_page;
      out_fault_r    <= fault_cnt_nxt;
      out_done_r     <= eor_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_used    = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;
  assign out_run_done      = out_done_r;

  // every strobe comes from exactly one execute cycle
  a_strobe_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid_r == $past(cmd.execute)))
    else $error("result strobe without matching execute");

  // an eviction only happens on a fault
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_valid_r |-> !out_hit_r && (out_fault_r != '0))
    else $error("eviction reported on a hit");

  // within a run the fault counter never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && !eor_r |=> fault_cnt_r >= $past(fault_cnt_r))
    else $error("fault counter decreased within a run");

endmodule

`default_nettype wire

// File: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page-frame tracker. Each reference is looked up in
// all active frames; a hit refreshes the frame, a miss fills the first empty
// frame or evicts the least recently used one and counts a fault.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------
//   input    in_page, in_end_of_run                  start & !busy
//   result   out_hit, out_frame_used, out_evicted_*, out_valid, one cycle
//            out_fault_total, out_run_done
//   config   cfg_frames_in_use                       cfg_valid & cfg_ready
//
// The accept cycle registers a reference and the next cycle does the parallel
// compare, victim pick and table update in one pass. The result strobe is
// registered from the execute cycle, and start may be accepted again in the
// same cycle as the strobe; busy holds off new references during execute.
// Reset (synchronous, rst_n low) empties all frames, clears the fault count
// and sets frames_in_use to 3; no clearing pass is needed.
// The result receiver cannot stall; config writes are taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input transaction
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [lpr_pkg::PAGE_PORT_W-1:0]  in_page,
  input  wire logic                             in_end_of_run,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lpr_pkg::CFG_W-1:0]        cfg_frames_in_use,
  // result transaction
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic [lpr_pkg::FRAME_IDX_W-1:0]       out_frame_used,
  output logic                                  out_evicted_valid,
  output logic [lpr_pkg::PAGE_PORT_W-1:0]       out_evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]           out_fault_total,
  output logic                                  out_run_done
);

  lpr_pkg::dp_cmd_t cmd;

  // controller
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cmd       (cmd)
  );

  assign cfg_ready = !busy;

  // datapath
  lpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_page),
    .in_end_of_run     (in_end_of_run),
    .cfg_frames_in_use (cfg_frames_in_use),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_run_done      (out_run_done)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_page_replacement. A shadow LRU frame table
// predicts hit, frame, eviction, fault count and run marker for every
// accepted page reference. Directed tests cover fill, hit, eviction, end of
// run and odd frame counts, then random traffic over small page pools runs
// under each frame count setting, with random start gaps after the first phase.
// ----------------------------------------------------------------------------

module tb;

  localparam int FRAMES = 4;

  // one reference outcome, as seen on the result ports
  typedef struct packed {
    logic                            hit;
    logic [lpr_pkg::FRAME_IDX_W-1:0] frame_used;
    logic                            ev_valid;
    logic [lpr_pkg::PAGE_PORT_W-1:0] ev_page;
    logic [lpr_pkg::FAULT_W-1:0]     fault_total;
    logic                            run_done;
  } page_result_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [lpr_pkg::PAGE_PORT_W-1:0] in_page = '0;
  logic                            in_end_of_run = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lpr_pkg::CFG_W-1:0]       cfg_frames_in_use = '0;
  logic                            out_valid;
  logic                            out_hit;
  logic [lpr_pkg::FRAME_IDX_W-1:0] out_frame_used;
  logic                            out_evicted_valid;
  logic [lpr_pkg::PAGE_PORT_W-1:0] out_evicted_page;
  logic [lpr_pkg::FAULT_W-1:0]     out_fault_total;
  logic                            out_run_done;

  // shadow frame table
  logic [lpr_pkg::PAGE_PORT_W-1:0] fr_page [FRAMES];
  logic                            fr_valid [FRAMES];
  logic [lpr_pkg::FRAME_IDX_W-1:0] fr_rank [FRAMES];
  logic [lpr_pkg::FAULT_W-1:0]     fault_cnt;
  logic [lpr_pkg::CFG_W-1:0]       frames_cfg;

  page_result_t pending_results [$];
  int err_count = 0;
  int idle_pct = 24;

  lru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page           (in_page),
    .in_end_of_run     (in_end_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_run_done      (out_run_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_frames();
    for (int i = 0; i < FRAMES; i++) begin
      fr_page[i]  = '0;
      fr_valid[i] = 1'b0;
      fr_rank[i]  = '0;
    end
    fault_cnt = '0;
  endfunction

  function automatic void age_rank(int i);
    if (fr_rank[i] < FRAMES - 1) fr_rank[i]++;
  endfunction

  // lookup, replacement and fault count for one reference
  function automatic page_result_t lru_predict(logic [lpr_pkg::PAGE_PORT_W-1:0] pg,
                                               logic eor);
    page_result_t res;
    int n;
    int slot;
    bit found;
    bit empty_seen;
    logic [lpr_pkg::FRAME_IDX_W-1:0] old_rank;
    res = '0;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    slot = 0;
    found = 1'b0;
    empty_seen = 1'b0;
    for (int i = 0; i < n; i++)
      if (!found && fr_valid[i] && fr_page[i] == pg) begin
        found = 1'b1;
        slot = i;
      end
    if (found) begin
      // hit: only frames younger than the hit frame get older
      old_rank = fr_rank[slot];
      res.hit = 1'b1;
      for (int i = 0; i < n; i++)
        if (i != slot && fr_valid[i] && fr_rank[i] < old_rank) age_rank(i);
      fr_rank[slot] = '0;
    end else begin
      // miss: lowest empty frame first, else oldest rank, lowest index on a tie
      for (int i = 0; i < n; i++)
        if (!empty_seen && !fr_valid[i]) begin
          empty_seen = 1'b1;
          slot = i;
        end
      if (!empty_seen) begin
        slot = 0;
        for (int i = 1; i < n; i++)
          if (fr_rank[i] > fr_rank[slot]) slot = i;
        res.ev_valid = 1'b1;
        res.ev_page  = fr_page[slot];
      end
      for (int i = 0; i < n; i++)
        if (i != slot && fr_valid[i]) age_rank(i);
      fr_page[slot]  = pg;
      fr_valid[slot] = 1'b1;
      fr_rank[slot]  = '0;
      if (fault_cnt != lpr_pkg::FAULT_MAX) fault_cnt++;
    end
    res.frame_used  = lpr_pkg::FRAME_IDX_W'(slot);
    res.fault_total = fault_cnt;
    res.run_done    = eor;
    if (eor) clear_frames();
    return res;
  endfunction

  // one reference transaction, start held high across back-to-back items
  task automatic send_ref(logic [lpr_pkg::PAGE_PORT_W-1:0] pg, logic eor);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start         <= 1'b1;
    in_page       <= pg;
    in_end_of_run <= eor;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(lru_predict(pg, eor));
  endtask

  // stop sending, wait for every outstanding result, then let the block settle
  task automatic wait_idle(int settle);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_frames(logic [lpr_pkg::CFG_W-1:0] val);
    wait_idle(3);
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames_cfg = val;
  endtask

  // result checker
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: expected none actual hit=%0b frame=%0d",
                 $time, out_hit, out_frame_used);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("frame_used", 32'(want.frame_used), 32'(out_frame_used));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(out_evicted_valid));
        check_field("evicted_page", 32'(want.ev_page), 32'(out_evicted_page));
        check_field("fault_total", want.fault_total, out_fault_total);
        check_field("run_done", 32'(want.run_done), 32'(out_run_done));
      end
    end
  end

  // fill, hit on resident pages, eviction of the oldest frame (reset setting)
  task automatic test_fill_evict();
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h8001, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5555, 1'b0);
  endtask

  // last reference of a run clears the table and the fault count
  task automatic test_end_of_run();
    send_ref(16'hABCD, 1'b0);
    send_ref(16'hABCD, 1'b1);
    send_ref(16'hABCD, 1'b0);
  endtask

  // zero acts as one frame, values above the table size act as all frames
  task automatic test_cfg_extremes();
    write_frames(3'd0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0002, 1'b0);
    write_frames(3'd7);
    send_ref(16'h0010, 1'b0);
    send_ref(16'h0011, 1'b0);
    send_ref(16'h0012, 1'b0);
    send_ref(16'h0013, 1'b0);
    send_ref(16'h0014, 1'b0);
    send_ref(16'h0011, 1'b0);
  endtask

  // frames outside the active count keep their pages and stale ranks
  task automatic test_cfg_mid_run();
    write_frames(3'd2);
    send_ref(16'h0020, 1'b0);
    send_ref(16'h0013, 1'b0);
    write_frames(3'd4);
    send_ref(16'h0013, 1'b0);
    send_ref(16'h0012, 1'b1);
  endtask

  // random references drawn mostly from a small page pool so hits are common;
  // the fault counter cannot reach saturation in a run of this length
  task automatic test_random_traffic();
    logic [lpr_pkg::CFG_W-1:0] cfg_seq [7];
    logic [lpr_pkg::PAGE_PORT_W-1:0] pool [8];
    logic [lpr_pkg::PAGE_PORT_W-1:0] pg;
    int span;
    cfg_seq = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5};
    for (int k = 0; k < 8; k++) pool[k] = lpr_pkg::PAGE_PORT_W'($urandom);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) cfg_seq[ph] = lpr_pkg::CFG_W'($urandom_range(0, 7));
      write_frames(cfg_seq[ph]);
      // first phase runs with no random sender gaps
      idle_pct = (ph == 0) ? 0 : 24;
      span = $urandom_range(1, 7);
      for (int j = 0; j < 250; j++) begin
        if ($urandom_range(0, 99) < 85) pg = pool[3'($urandom_range(0, span))];
        else pg = lpr_pkg::PAGE_PORT_W'($urandom);
        if ($urandom_range(0, 99) < 3)
          pool[3'($urandom_range(0, 7))] = lpr_pkg::PAGE_PORT_W'($urandom);
        if ($urandom_range(0, 99) < 2) span = $urandom_range(1, 7);
        send_ref(pg, $urandom_range(0, 49) == 0);
        // sender holds off until the pipeline is empty
        if ($urandom_range(0, 99) == 0 || (ph == 1 && j == 100)) wait_idle(0);
      end
    end
  endtask

  // main sequence
  initial begin
    frames_cfg = lpr_pkg::CFG_RESET;
    clear_frames();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_evict();
    test_end_of_run();
    test_cfg_extremes();
    test_cfg_mid_run();
    test_random_traffic();
    wait_idle(4);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
